// ===== design/rc4_pkg.sv =====
// Shared constants, codes and types of the RC4 cipher block.
package rc4_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PermSize  = 256;
  localparam int unsigned PermAw    = $clog2(PermSize);
  localparam int unsigned KeyMaxDef = 256;

  localparam logic [PermAw-1:0] PermLast = PermAw'(PermSize - 1);

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic {
    ReqKey  = 1'b0,
    ReqData = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [PermAw-1:0] waddr;
    byte_t             wdata;
    logic [PermAw-1:0] raddr;
  } perm_req_t;

endpackage

// ===== design/rc4_if.sv =====
// Request and response channel interfaces of the RC4 cipher block.
interface rc4_req_if import rc4_pkg::*;;
  logic  valid;
  logic  ready;
  logic  req_type;
  byte_t in_byte;
  logic  key_last;

  modport source (output valid, output req_type, output in_byte, output key_last,
                  input ready);
  modport sink (input valid, input req_type, input in_byte, input key_last,
                output ready);
endinterface

interface rc4_rsp_if import rc4_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

// ===== design/rc4_perm_mem.sv =====
// Permutation memory: 256 x 8 RAM, registered read, valid bits give identity until written.
module rc4_perm_mem import rc4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  perm_req_t req_i,
  output byte_t     rdata_o
);

  byte_t             mem [PermSize];
  logic [PermSize-1:0] vld_q;
  byte_t             rdata_q;
  logic              rvld_q;
  logic [PermAw-1:0] raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
    rvld_q  <= vld_q[req_i.raddr];
    raddr_q <= req_i.raddr;
  end

  assign rdata_o = rvld_q ? rdata_q : byte_t'(raddr_q);

endmodule

// ===== design/rc4_key_mem.sv =====
// Key store: KeyMax x 8 RAM with one write and one registered read port.
module rc4_key_mem import rc4_pkg::*; #(
  parameter int unsigned KeyMax = KeyMaxDef,
  localparam int unsigned KeyAw = (KeyMax > 1) ? $clog2(KeyMax) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [KeyAw-1:0] waddr_i,
  input  byte_t            wdata_i,
  input  logic [KeyAw-1:0] raddr_i,
  output byte_t            rdata_o
);

  byte_t mem [KeyMax];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rc4_stream_cipher.sv =====
// RC4 cipher top level: sequencer over the permutation and key memories.
// Key byte without last mark: stored, stays ready. Last key byte: key schedule,
// four permutation memory accesses per step, all 256 entries. Data byte: StDRdJ
// to StDOut (stalls in StDOut on a held result); no new item before StIdle.
// Reset (async, active low) sets the identity permutation at once via per-entry
// valid bits, clears indices and key count; the key store holds no reset value.
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int unsigned KeyMax = KeyMaxDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rc4_req_if.sink  req_i,
  rc4_rsp_if.source rsp_o
);

  localparam int unsigned KeyAw = (KeyMax > 1) ? $clog2(KeyMax) : 1;
  localparam int unsigned CntW  = $clog2(KeyMax + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(KeyMax);

  typedef enum logic [9:0] {
    StIdle = 10'b0000000001,
    StDRdJ = 10'b0000000010,
    StDWrI = 10'b0000000100,
    StDWrJ = 10'b0000001000,
    StDRdK = 10'b0000010000,
    StDOut = 10'b0000100000,
    StKRd  = 10'b0001000000,
    StKJ   = 10'b0010000000,
    StKWk  = 10'b0100000000,
    StKWj  = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [PermAw-1:0] i_q, i_d;
  logic [PermAw-1:0] j_q, j_d;
  logic [KeyAw-1:0]  pos_q, pos_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   len_q, len_d;
  byte_t             sa_q, sa_d;
  byte_t             sb_q, sb_d;
  logic [PermAw-1:0] t_q, t_d;
  byte_t             byte_q, byte_d;
  byte_t             out_q, out_d;
  logic              out_vld_q, out_vld_d;

  perm_req_t         preq;
  byte_t             prd;
  logic              kwe;
  byte_t             krd;
  logic              accept;
  logic              key_room;
  logic              out_free;
  logic [PermAw-1:0] jn;

  rc4_perm_mem u_perm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (preq),
    .rdata_o(prd)
  );

  rc4_key_mem #(
    .KeyMax(KeyMax)
  ) u_key (
    .clk_i  (clk_i),
    .we_i   (kwe),
    .waddr_i(cnt_q[KeyAw-1:0]),
    .wdata_i(req_i.in_byte),
    .raddr_i(pos_q),
    .rdata_o(krd)
  );

  assign req_i.ready    = (state_q == StIdle);
  assign accept         = req_i.valid && req_i.ready;
  assign key_room       = (cnt_q < CntMax);
  assign out_free       = !out_vld_q || rsp_o.ready;
  assign jn             = PermAw'(j_q + prd + krd);
  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.out_byte = out_q;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    t_d       = t_q;
    byte_d    = byte_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    kwe       = 1'b0;
    preq      = '0;
    preq.raddr = i_q;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        preq.raddr = PermAw'(i_q + 1'b1);
        if (accept) begin
          if (req_i.req_type == ReqData) begin
            i_d     = PermAw'(i_q + 1'b1);
            byte_d  = req_i.in_byte;
            state_d = StDRdJ;
          end else begin
            if (key_room) begin
              kwe   = 1'b1;
              cnt_d = CntW'(cnt_q + 1'b1);
            end
            if (req_i.key_last) begin
              len_d     = cnt_d;
              cnt_d     = '0;
              i_d       = '0;
              j_d       = '0;
              pos_d     = '0;
              preq.clr  = 1'b1;
              state_d   = StKRd;
            end
          end
        end
      end
      StDRdJ: begin
        j_d        = PermAw'(j_q + prd);
        sa_d       = prd;
        preq.raddr = PermAw'(j_q + prd);
        state_d    = StDWrI;
      end
      StDWrI: begin
        preq.we    = 1'b1;
        preq.waddr = i_q;
        preq.wdata = prd;
        sb_d       = prd;
        state_d    = StDWrJ;
      end
      StDWrJ: begin
        preq.we    = 1'b1;
        preq.waddr = j_q;
        preq.wdata = sa_q;
        t_d        = PermAw'(sa_q + sb_q);
        state_d    = StDRdK;
      end
      StDRdK: begin
        preq.raddr = t_q;
        state_d    = StDOut;
      end
      StDOut: begin
        preq.raddr = t_q;
        if (out_free) begin
          out_d     = prd ^ byte_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      StKRd: begin
        preq.raddr = i_q;
        state_d    = StKJ;
      end
      StKJ: begin
        j_d        = jn;
        sa_d       = prd;
        preq.raddr = jn;
        state_d    = StKWk;
      end
      StKWk: begin
        preq.we    = 1'b1;
        preq.waddr = i_q;
        preq.wdata = prd;
        state_d    = StKWj;
      end
      StKWj: begin
        preq.we    = 1'b1;
        preq.waddr = j_q;
        preq.wdata = sa_q;
        i_d        = PermAw'(i_q + 1'b1);
        if (CntW'(CntW'(pos_q) + 1'b1) >= len_q) begin
          pos_d = '0;
        end else begin
          pos_d = KeyAw'(pos_q + 1'b1);
        end
        if (i_q == PermLast) begin
          j_d     = '0;
          state_d = StIdle;
        end else begin
          state_d = StKRd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      i_q       <= '0;
      j_q       <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      len_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    t_q    <= t_d;
    byte_q <= byte_d;
    out_q  <= out_d;
  end

endmodule

// ===== design/rc4_sva.sv =====
// Port-level timing checks of the RC4 cipher, bound to the top level.
module rc4_sva import rc4_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  rc4_req_if.sink    req_i,
  rc4_rsp_if.source  rsp_o
);

  logic data_acc;
  logic key_acc;

  assign data_acc = req_i.valid && req_i.ready && (req_i.req_type == ReqData);
  assign key_acc  = req_i.valid && req_i.ready && (req_i.req_type == ReqKey);

  // data transaction keeps the block busy until its result is formed
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_acc |=> !req_i.ready ##1 !req_i.ready ##1 !req_i.ready ##1 !req_i.ready)
    else $error("request taken during data processing");

  // a newly valid result must trace back to an accepted data transaction
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(data_acc, 6))
    else $error("result without matching data transaction");

  // plain key byte leaves the block ready on the next cycle
  a_key_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_acc && !req_i.key_last) |=> req_i.ready)
    else $error("key byte stalled the request side");

  // last key byte starts the schedule
  a_key_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_acc && req_i.key_last) |=> !req_i.ready ##1 !req_i.ready ##1 !req_i.ready)
    else $error("key schedule did not hold off requests");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> rsp_o.valid && $stable(rsp_o.out_byte))
    else $error("stalled result changed");

endmodule

bind rc4_stream_cipher rc4_sva u_rc4_sva (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req_i (req_i),
  .rsp_o (rsp_o)
);
